@@ rtl/tcbh_pkg.sv @@
package tcbh_pkg;

	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned CHAIN_BYTES = 16;
	localparam int unsigned BLOCK_BYTES = 32;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned FILL_W      = 6;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h35;
	localparam logic [CHAR_W-1:0] MAP_BASE = 7'd33;
	localparam logic [8:0]        MAP_MOD  = 9'd92;
	localparam logic [8:0]        MAP_MOD2 = 9'd184;

	localparam logic [IDX_W-1:0]  JOIN_LAST  = 6'd47;
	localparam logic [IDX_W-1:0]  CHAIN_LAST = 6'd15;
	localparam logic [IDX_W-1:0]  BLOCK_OFS  = 6'd16;
	localparam logic [FILL_W-1:0] FILL_LAST  = 6'd31;

	localparam logic [CHAR_W-1:0] INIT_CHAIN [CHAIN_BYTES] = '{
		7'h58, 7'h41, 7'h4C, 7'h53, 7'h4A, 7'h24, 7'h44, 7'h49,
		7'h31, 7'h38, 7'h39, 7'h44, 7'h23, 7'h4B, 7'h4C, 7'h46
	};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_MIX  = 4'b0100,
		ST_EMIT = 4'b1000
	} tcbh_state_t;

	typedef struct packed {
		logic accept;
		logic sum_start;
		logic sum_step;
		logic mix_start;
		logic mix_step;
		logic mix_done;
		logic emit_start;
		logic emit_step;
		logic emit_done;
	} tcbh_cmd_t;

	typedef struct packed {
		logic join_end;
		logic chain_end;
		logic fill_last;
		logic out_free;
	} tcbh_sts_t;

	// valid only for v < 276
	function automatic logic [CHAR_W-1:0] mod92(input logic [8:0] v);
		logic [8:0] r;
		if (v >= MAP_MOD2) begin
			r = v - MAP_MOD2;
		end else if (v >= MAP_MOD) begin
			r = v - MAP_MOD;
		end else begin
			r = v;
		end
		return r[CHAR_W-1:0];
	endfunction

	function automatic logic [CHAR_W-1:0] map_char(input logic [8:0] v);
		return MAP_BASE + mod92(v);
	endfunction

endpackage

@@ rtl/toy_chained_block_hash.sv @@
// Chained 32-byte-block toy hash over 7-bit characters.
// Input channel: msg_byte/is_last with in_valid/in_stall. One byte is
// transferred per cycle while the block is filling; is_last marks the final
// byte of a message.
// Output channel: digest_char/digest_last with out_valid/out_stall. After the
// final byte, 16 digest characters follow, digest_last set on the sixteenth.
// Compression of each block runs on one shared step unit: a key-summing pass
// over the 48 joined bytes, then a pair-mixing pass, one joined byte per
// cycle, and the input is stalled throughout. After the final byte has been
// taken and its block compressed, the digest characters follow one per cycle
// while the receiver does not stall.
// The digest sits in an output register: when the receiver stalls, emission
// holds, and the last character can wait there while the next message begins.
// Reset (arst_n low) loads the initial chaining value, empties the block and
// clears the output valid; the block then accepts bytes at once.
module toy_chained_block_hash
	import tcbh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] msg_byte,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] digest_char,
	output logic              digest_last
);

	tcbh_cmd_t cmd;
	tcbh_sts_t sts;

	tcbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcbh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.msg_byte    (msg_byte),
		.digest_char (digest_char),
		.digest_last (digest_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

endmodule

@@ rtl/tcbh_ctrl.sv @@
module tcbh_ctrl
	import tcbh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      is_last,
	output logic      in_stall,
	input  tcbh_sts_t sts,
	output tcbh_cmd_t cmd
);

	tcbh_state_t state_q, state_d;
	logic        last_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && (is_last || sts.fill_last)) begin
					cmd.sum_start = 1'b1;
					state_d       = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.join_end) begin
					cmd.mix_start = 1'b1;
					state_d       = ST_MIX;
				end
			end
			ST_MIX: begin
				cmd.mix_step = 1'b1;
				if (sts.join_end) begin
					cmd.mix_done = 1'b1;
					if (last_q) begin
						cmd.emit_start = 1'b1;
						state_d        = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				// hold while the output register is still occupied
				cmd.emit_step = sts.out_free;
				if (sts.out_free && sts.chain_end) begin
					cmd.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				last_q <= is_last;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == ST_IDLE)
		else $error("transfer taken outside idle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> sts.out_free)
		else $error("digest char loaded over a pending one");

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sum_step && cmd.mix_step))
		else $error("sum and mix steps overlap");

	a_mix_follows_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix_start |=> state_q == ST_MIX)
		else $error("mix pass did not start after sum pass");
`endif

endmodule

@@ rtl/tcbh_datapath.sv @@
module tcbh_datapath
	import tcbh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tcbh_cmd_t         cmd,
	output tcbh_sts_t         sts,
	input  logic [CHAR_W-1:0] msg_byte,
	output logic [CHAR_W-1:0] digest_char,
	output logic              digest_last,
	output logic              out_valid,
	input  logic              out_stall
);

	logic [CHAR_W-1:0] chain_q [CHAIN_BYTES];
	logic [CHAR_W-1:0] buf_q   [BLOCK_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CHAR_W-1:0] acc_q;
	logic [CHAR_W-1:0] xprev_q;
	logic [CHAR_W-1:0] tri_x_q;
	logic [1:0]        tri_cnt_q;
	logic [3:0]        widx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] digest_char_q;
	logic              digest_last_q;

	logic [IDX_W-1:0]  b_off;
	logic [CHAR_W-1:0] chain_rd, buf_rd, xv, prev, key, e_val, tri_mix;

	assign b_off    = idx_q - BLOCK_OFS;
	assign chain_rd = chain_q[idx_q[3:0]];
	assign buf_rd   = (b_off >= fill_q) ? PAD_CHAR : buf_q[b_off[4:0]];
	assign xv       = (idx_q < BLOCK_OFS) ? chain_rd : buf_rd;
	assign key      = MAP_BASE + acc_q;
	assign prev     = (idx_q == '0) ? key : xprev_q;
	assign e_val    = map_char({2'b00, prev} + {2'b00, xv}) ^ xv;
	assign tri_mix  = tri_x_q ^ e_val;

	assign sts.join_end  = (idx_q == JOIN_LAST);
	assign sts.chain_end = (idx_q == CHAIN_LAST);
	assign sts.fill_last = (fill_q == FILL_LAST);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign digest_char = digest_char_q;
	assign digest_last = digest_last_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			buf_q[fill_q[4:0]] <= msg_byte;
		end
		if (cmd.mix_step) begin
			xprev_q <= xv;
		end
		if (cmd.emit_step) begin
			digest_char_q <= chain_rd;
			digest_last_q <= sts.chain_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHAIN_BYTES; k++) begin
				chain_q[k] <= INIT_CHAIN[k];
			end
			fill_q      <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			tri_x_q     <= '0;
			tri_cnt_q   <= '0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mix_done) begin
				fill_q <= '0;
			end else if (cmd.accept) begin
				fill_q <= fill_q + 1'b1;
			end

			if (cmd.sum_start || cmd.mix_start || cmd.emit_start || cmd.mix_done) begin
				idx_q <= '0;
			end else if (cmd.sum_step || cmd.mix_step || cmd.emit_step) begin
				idx_q <= idx_q + 1'b1;
			end

			// keep the running sum reduced so it stays narrow
			if (cmd.sum_start) begin
				acc_q <= '0;
			end else if (cmd.sum_step) begin
				acc_q <= mod92({2'b00, acc_q} + {2'b00, xv});
			end

			if (cmd.mix_start) begin
				tri_x_q   <= '0;
				tri_cnt_q <= '0;
				widx_q    <= '0;
			end else if (cmd.mix_step) begin
				if (tri_cnt_q == 2'd2) begin
					// chain entry already consumed as x, safe to overwrite
					chain_q[widx_q] <= map_char({2'b00, tri_mix});
					tri_x_q         <= '0;
					tri_cnt_q       <= '0;
					widx_q          <= widx_q + 1'b1;
				end else begin
					tri_x_q   <= tri_mix;
					tri_cnt_q <= tri_cnt_q + 1'b1;
				end
			end

			if (cmd.emit_done) begin
				for (int k = 0; k < CHAIN_BYTES; k++) begin
					chain_q[k] <= INIT_CHAIN[k];
				end
			end

			if (cmd.emit_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BLOCK_BYTES))
		else $error("fill count past block size");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= JOIN_LAST)
		else $error("step index past joined block");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
	import tcbh_pkg::*;

	localparam int RAND_BYTES  = 200;
	localparam int HOLD_AT     = 130;
	localparam int HOLD_CYCLES = 1000;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;
	localparam int N_ROWS      = 6;

	typedef struct {
		logic [CHAR_W-1:0] b;
		logic              l;
		int                reps;
	} stim_row_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              lst;
	} digest_t;

	// each row sends reps copies of b; is_last goes only on the final copy
	stim_row_t dir_rows [N_ROWS] = '{
		'{7'h00, 1'b1, 1},
		'{7'h7F, 1'b1, 1},
		'{7'h55, 1'b0, 1},
		'{7'h2A, 1'b1, 1},
		'{7'h7F, 1'b1, 32},
		'{PAD_CHAR, 1'b1, 6}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CHAR_W-1:0] msg_byte;
	logic              is_last;
	logic              out_valid;
	logic              out_stall;
	logic [CHAR_W-1:0] digest_char;
	logic              digest_last;

	logic [7:0] chain_st [CHAIN_BYTES];
	logic [7:0] blk_buf [BLOCK_BYTES];
	int         fill_cnt;
	digest_t    digest_q [$];

	int  errors;
	int  results_seen;
	int  quiet_cycles;
	bit  in_calm;

	toy_chained_block_hash u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.msg_byte    (msg_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_char (digest_char),
		.digest_last (digest_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	task automatic load_init_chain();
		for (int k = 0; k < CHAIN_BYTES; k++)
			chain_st[k] = {1'b0, INIT_CHAIN[k]};
	endtask

	// one compression: key from the byte sum, pair mix, xor with x, fold triplets
	task automatic compress_block();
		int unsigned x [48];
		int unsigned e [48];
		int unsigned total;
		int unsigned key;
		total = 0;
		for (int i = 0; i < CHAIN_BYTES; i++)
			x[i] = chain_st[i];
		for (int i = 0; i < BLOCK_BYTES; i++)
			x[CHAIN_BYTES + i] = blk_buf[i];
		for (int i = 0; i < 48; i++)
			total += x[i];
		key = 33 + total % 92;
		e[0] = 33 + (key + x[0]) % 92;
		for (int i = 1; i < 48; i++)
			e[i] = 33 + (x[i-1] + x[i]) % 92;
		for (int i = 0; i < 48; i++)
			e[i] = (e[i] ^ x[i]) & 8'hFF;
		for (int i = 0; i < CHAIN_BYTES; i++)
			chain_st[i] = 8'(33 + (e[3*i] ^ e[3*i+1] ^ e[3*i+2]) % 92);
	endtask

	task automatic hash_absorb(input logic [CHAR_W-1:0] b, input logic l);
		digest_t d;
		blk_buf[fill_cnt] = {1'b0, b};
		fill_cnt++;
		if (fill_cnt == BLOCK_BYTES) begin
			compress_block();
			fill_cnt = 0;
		end
		if (l) begin
			if (fill_cnt != 0) begin
				for (int j = fill_cnt; j < BLOCK_BYTES; j++)
					blk_buf[j] = {1'b0, PAD_CHAR};
				compress_block();
				fill_cnt = 0;
			end
			for (int k = 0; k < CHAIN_BYTES; k++) begin
				d.ch  = chain_st[k][CHAR_W-1:0];
				d.lst = (k == CHAIN_BYTES - 1);
				digest_q = {digest_q, d};
			end
			load_init_chain();
		end
	endtask

	// predict on input transfers, check output transfers, watch for a hang
	always @(posedge clk) begin
		digest_t d;
		if (arst_n) begin
			if (in_valid && !in_stall)
				hash_absorb(msg_byte, is_last);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest_char", -1, digest_char);
				end else begin
					d = digest_q.pop_front();
					if (digest_char !== d.ch)
						report_mismatch("digest_char", d.ch, digest_char);
					if (digest_last !== d.lst)
						report_mismatch("digest_last", d.lst, digest_last);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [CHAR_W-1:0] b, input logic l);
		int gap;
		if ($urandom_range(0, 15) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 9);
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		msg_byte = b;
		is_last  = l;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_digest_drained();
		while (digest_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin : receiver
		int gap;
		bit held;
		bit calm;
		held = 1'b0;
		calm = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 9);
			// hold off long enough for the block to back up into its input
			if (!held && results_seen >= HOLD_AT) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : sender
		int sent;
		int msg_no;
		int len;
		int pick;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		msg_byte = '0;
		is_last  = 1'b0;
		in_calm  = 1'b0;
		errors   = 0;
		results_seen = 0;
		quiet_cycles = 0;
		fill_cnt = 0;
		sent     = 0;
		msg_no   = 0;
		load_init_chain();
		for (int i = 0; i < BLOCK_BYTES; i++)
			blk_buf[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < N_ROWS; r++)
			for (int n = 0; n < dir_rows[r].reps; n++)
				send_byte(dir_rows[r].b, dir_rows[r].l && (n == dir_rows[r].reps - 1));
		wait_digest_drained();

		// mostly short messages, some across a block edge, a few exact multiples
		while (sent < RAND_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 31);
			else if (pick < 8)
				len = $urandom_range(33, 70);
			else if (pick == 8)
				len = BLOCK_BYTES;
			else
				len = 2 * BLOCK_BYTES;
			for (int i = 0; i < len; i++)
				send_byte(CHAR_W'($urandom_range(0, 127)), i == len - 1);
			sent += len;
			msg_no++;
			if (msg_no == 6)
				wait_digest_drained();
		end

		wait_digest_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
